### design/ogp_pkg.sv
// ============================================================================
// ogp_pkg
// Shared types, constants and the quarter-wave sine table for the
// orthographic globe projection pipeline.
// ============================================================================
package ogp_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_VIEW_LAT   = 2'd0;
    localparam logic [1:0] CFG_VIEW_LON   = 2'd1;
    localparam logic [1:0] CFG_ZOOM_LEVEL = 2'd2;

    // Radius table, indexed by the clamped zoom level.
    localparam int RADIUS_ENTRIES = 6;
    typedef logic [9:0] radius_tab_t [0:RADIUS_ENTRIES-1];
    localparam radius_tab_t RADIUS_TAB = '{10'd90, 10'd120, 10'd180, 10'd280, 10'd450, 10'd720};

    // One input transaction.
    typedef struct packed {
        logic [15:0] point_lat;
        logic [15:0] point_lon;
    } point_t;

    // One result transaction.
    typedef struct packed {
        logic       visible;
        logic [7:0] screen_x;
        logic [7:0] screen_y;
    } result_t;

    // Sine and cosine terms handed from the lookup stages to the rotation stages.
    typedef struct packed {
        logic signed [15:0] sp;
        logic signed [15:0] cp;
        logic signed [15:0] sd;
        logic signed [15:0] cd;
        logic signed [15:0] sc;
        logic signed [15:0] cc;
    } trig_t;

    // Rotated point handed from the rotation stages to the screen stages.
    typedef struct packed {
        logic               front;
        logic signed [15:0] u;
        logic signed [15:0] v;
    } proj_t;

    // Quarter-wave table of round(16384*sin(k*90deg/1024)), k = 0..1024.
    localparam int SINE_LAST = 1024;
    typedef logic [14:0] sine_tab_t [0:SINE_LAST];

    // pi/2048 in Q62.
    localparam logic [63:0] SINE_STEP = 64'h3243F6A8885A308D >> 9;

    // Product of two unsigned Q62 values, kept in Q62.
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // Taylor series evaluated once per entry at elaboration.
    function automatic sine_tab_t build_sine_tab();
        sine_tab_t   t;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        for (int k = 0; k <= SINE_LAST; k++)
        begin
            x    = SINE_STEP * 64'(k);
            x2   = mul_q62(x, x);
            term = x;
            sum  = x;
            term = mul_q62(term, x2) / 64'd6;   sum = sum - term;
            term = mul_q62(term, x2) / 64'd20;  sum = sum + term;
            term = mul_q62(term, x2) / 64'd42;  sum = sum - term;
            term = mul_q62(term, x2) / 64'd72;  sum = sum + term;
            term = mul_q62(term, x2) / 64'd110; sum = sum - term;
            term = mul_q62(term, x2) / 64'd156; sum = sum + term;
            term = mul_q62(term, x2) / 64'd210; sum = sum - term;
            term = mul_q62(term, x2) / 64'd272; sum = sum + term;
            term = mul_q62(term, x2) / 64'd342; sum = sum - term;
            term = mul_q62(term, x2) / 64'd420; sum = sum + term;
            term = mul_q62(term, x2) / 64'd506; sum = sum - term;
            term = mul_q62(term, x2) / 64'd600; sum = sum + term;
            term = mul_q62(term, x2) / 64'd702; sum = sum - term;
            t[k] = 15'((sum + (64'd1 << 47)) >> 48);
        end
        return t;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine_tab();

    // Full-circle sine of a 16-bit angle, Q14.
    function automatic logic signed [15:0] sin_lookup(input logic [15:0] a);
        logic [10:0]        idx;
        logic signed [15:0] v;
        idx = a[14] ? (11'd1024 - {1'b0, a[13:4]}) : {1'b0, a[13:4]};
        v   = signed'({1'b0, SINE_TAB[idx]});
        return a[15] ? -v : v;
    endfunction

    // Full-circle cosine of a 16-bit angle, Q14.
    function automatic logic signed [15:0] cos_lookup(input logic [15:0] a);
        return sin_lookup(a + 16'h4000);
    endfunction

endpackage

### design/ogp_trig.sv
// ============================================================================
// ogp_trig
// Stages 1 and 2: registers the angles of a transaction, then looks up the
// sine and cosine of the point latitude, the longitude offset and the view
// latitude in the constant table.
// ============================================================================
module ogp_trig
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [15:0]       lat,
    input  logic [15:0]       dlon,
    input  logic [15:0]       view_lat,
    output logic              out_valid,
    output ogp_pkg::trig_t    trig
);

    logic           s1_valid_reg;
    logic [15:0]    lat_reg;
    logic [15:0]    dlon_reg;
    logic [15:0]    vlat_reg;
    logic           s2_valid_reg;
    ogp_pkg::trig_t trig_reg;
    ogp_pkg::trig_t trig_next;

    // Valid bits of both stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // Table reads for the registered angles.
    always_comb
    begin
        trig_next.sp = ogp_pkg::sin_lookup(lat_reg);
        trig_next.cp = ogp_pkg::cos_lookup(lat_reg);
        trig_next.sd = ogp_pkg::sin_lookup(dlon_reg);
        trig_next.cd = ogp_pkg::cos_lookup(dlon_reg);
        trig_next.sc = ogp_pkg::sin_lookup(vlat_reg);
        trig_next.cc = ogp_pkg::cos_lookup(vlat_reg);
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        lat_reg  <= lat;
        dlon_reg <= dlon;
        vlat_reg <= view_lat;
        trig_reg <= trig_next;
    end

    assign out_valid = s2_valid_reg;
    assign trig      = trig_reg;

endmodule

### design/ogp_rotate.sv
// ============================================================================
// ogp_rotate
// Stages 3 to 5: rotates the point on the unit sphere into view coordinates
// and decides whether it lies on the front hemisphere.
// ============================================================================
module ogp_rotate
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  ogp_pkg::trig_t    trig,
    output logic              out_valid,
    output ogp_pkg::proj_t    proj
);

    logic                      s3_valid_reg;
    logic                      s4_valid_reg;
    logic                      s5_valid_reg;

    logic signed [31:0]        pc_prod;
    logic signed [31:0]        u_prod;
    logic signed [15:0]        pc_reg;
    logic signed [15:0]        u3_reg;
    logic signed [15:0]        sp3_reg;
    logic signed [15:0]        sc3_reg;
    logic signed [15:0]        cc3_reg;

    logic signed [31:0]        ccpc_reg;
    logic signed [31:0]        scsp_reg;
    logic signed [31:0]        ccsp_reg;
    logic signed [31:0]        scpc_reg;
    logic signed [15:0]        u4_reg;

    logic signed [32:0]        depth_sum;
    logic signed [31:0]        v_diff;
    ogp_pkg::proj_t            proj_next;
    ogp_pkg::proj_t            proj_reg;

    // Valid bits of the three stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= in_valid;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    // Stage 3 products: cos(lat)*cos(dlon) and cos(lat)*sin(dlon), Q14.
    assign pc_prod = trig.cp * trig.cd;
    assign u_prod  = trig.cp * trig.sd;

    // Stage 5: depth test and vertical component.
    always_comb
    begin
        depth_sum       = 33'(ccpc_reg) + 33'(scsp_reg);
        v_diff          = ccsp_reg - scpc_reg;
        proj_next.front = !depth_sum[32];
        proj_next.u     = u4_reg;
        proj_next.v     = v_diff[29:14];
    end

    // Payload registers of stages 3 to 5.
    always_ff @(posedge clk)
    begin
        pc_reg   <= pc_prod[29:14];
        u3_reg   <= u_prod[29:14];
        sp3_reg  <= trig.sp;
        sc3_reg  <= trig.sc;
        cc3_reg  <= trig.cc;

        ccpc_reg <= cc3_reg * pc_reg;
        scsp_reg <= sc3_reg * sp3_reg;
        ccsp_reg <= cc3_reg * sp3_reg;
        scpc_reg <= sc3_reg * pc_reg;
        u4_reg   <= u3_reg;

        proj_reg <= proj_next;
    end

    assign out_valid = s5_valid_reg;
    assign proj      = proj_reg;

endmodule

### design/ogp_screen.sv
// ============================================================================
// ogp_screen
// Stages 6 and 7: scales the rotated point by the zoom radius, moves it to
// the screen center and applies the back-face and margin checks.
// ============================================================================
module ogp_screen
#(
    parameter int SCREEN_W    = 256,
    parameter int SCREEN_H    = 192,
    parameter int CENTER_X    = 128,
    parameter int CENTER_Y    = 96,
    parameter int ZOOM_LEVELS = 6
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  ogp_pkg::proj_t    proj,
    input  logic [2:0]        zoom_level,
    output logic              out_valid,
    output ogp_pkg::result_t  result
);

    localparam int ZOOM_LAST =
        ((ZOOM_LEVELS < ogp_pkg::RADIUS_ENTRIES) ? ZOOM_LEVELS : ogp_pkg::RADIUS_ENTRIES) - 1;
    localparam logic [2:0]         ZoomLastIdx = 3'(ZOOM_LAST);
    localparam logic signed [17:0] CenterX     = 18'(CENTER_X);
    localparam logic signed [17:0] CenterY     = 18'(CENTER_Y);
    localparam logic signed [17:0] MaxX        = 18'(SCREEN_W - 2);
    localparam logic signed [17:0] MaxY        = 18'(SCREEN_H - 2);
    localparam logic signed [17:0] MinPos      = 18'sd1;

    logic                s6_valid_reg;
    logic                s7_valid_reg;
    logic [2:0]          zoom_idx;
    logic signed [11:0]  radius;
    logic signed [31:0]  ru_reg;
    logic signed [31:0]  rv_reg;
    logic                front_reg;
    logic signed [15:0]  dx;
    logic signed [15:0]  dy;
    logic signed [17:0]  px;
    logic signed [17:0]  py;
    logic                on_screen;
    ogp_pkg::result_t    result_next;
    ogp_pkg::result_t    result_reg;

    // Valid bits of both stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
        end
        else
        begin
            s6_valid_reg <= in_valid;
            s7_valid_reg <= s6_valid_reg;
        end
    end

    // Zoom levels past the last usable entry (table end or ZOOM_LEVELS) use that entry.
    assign zoom_idx = (zoom_level < ZoomLastIdx) ? zoom_level : ZoomLastIdx;
    assign radius   = signed'({2'b00, ogp_pkg::RADIUS_TAB[zoom_idx]});

    // Stage 7: pixel position and visibility.
    always_comb
    begin
        dx        = ru_reg[29:14];
        dy        = rv_reg[29:14];
        px        = CenterX + 18'(dx);
        py        = CenterY + 18'(dy);
        on_screen = (px >= MinPos) && (px <= MaxX) && (py >= MinPos) && (py <= MaxY);
        if (front_reg && on_screen)
        begin
            result_next.visible  = 1'b1;
            result_next.screen_x = px[7:0];
            result_next.screen_y = py[7:0];
        end
        else
        begin
            result_next.visible  = 1'b0;
            result_next.screen_x = 8'd0;
            result_next.screen_y = 8'd0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        ru_reg     <= radius * proj.u;
        rv_reg     <= radius * proj.v;
        front_reg  <= proj.front;
        result_reg <= result_next;
    end

    assign out_valid = s7_valid_reg;
    assign result    = result_reg;

endmodule

### design/orthographic_globe_projection.sv
// ============================================================================
// orthographic_globe_projection
// Orthographic projection of latitude/longitude points onto a screen, with
// a configurable view latitude, view longitude and zoom radius.
// ============================================================================
// A point transaction is taken at every clock edge where start is high; busy
// is never raised, so one point per cycle is sustained. Each result appears
// on result with done high for one cycle; results cannot be held off. The
// register stages of the pipeline are two for the angle registers and sine
// table reads, three for the rotation multiplies and depth test, two for the
// zoom scaling and screen checks. Configuration writes take effect at once
// and belong between bursts of points, after the last result of the earlier
// points has come out.
module orthographic_globe_projection
#(
    parameter int SCREEN_W    = 256,
    parameter int SCREEN_H    = 192,
    parameter int CENTER_X    = 128,
    parameter int CENTER_Y    = 96,
    parameter int ZOOM_LEVELS = 6
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ogp_pkg::point_t   point,
    output logic              done,
    output ogp_pkg::result_t  result,
    input  logic              wr_en,
    input  logic [1:0]        wr_index,
    input  logic [15:0]       wr_data
);

    logic [15:0]      view_lat_reg;
    logic [15:0]      view_lon_reg;
    logic [2:0]       zoom_level_reg;
    logic             accept;
    logic [15:0]      dlon;
    logic             trig_valid;
    ogp_pkg::trig_t   trig;
    logic             proj_valid;
    ogp_pkg::proj_t   proj;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            view_lat_reg   <= 16'd0;
            view_lon_reg   <= 16'd0;
            zoom_level_reg <= 3'd0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                ogp_pkg::CFG_VIEW_LAT:   view_lat_reg   <= wr_data;
                ogp_pkg::CFG_VIEW_LON:   view_lon_reg   <= wr_data;
                ogp_pkg::CFG_ZOOM_LEVEL: zoom_level_reg <= wr_data[2:0];
                default:
                begin
                end
            endcase
        end
    end

    // The pipeline takes a transaction every cycle.
    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign dlon   = point.point_lon - view_lon_reg;

    ogp_trig u_trig
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .lat       (point.point_lat),
        .dlon      (dlon),
        .view_lat  (view_lat_reg),
        .out_valid (trig_valid),
        .trig      (trig)
    );

    ogp_rotate u_rotate
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (trig_valid),
        .trig      (trig),
        .out_valid (proj_valid),
        .proj      (proj)
    );

    ogp_screen
    #(
        .SCREEN_W    (SCREEN_W),
        .SCREEN_H    (SCREEN_H),
        .CENTER_X    (CENTER_X),
        .CENTER_Y    (CENTER_Y),
        .ZOOM_LEVELS (ZOOM_LEVELS)
    )
    u_screen
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (proj_valid),
        .proj       (proj),
        .zoom_level (zoom_level_reg),
        .out_valid  (done),
        .result     (result)
    );

endmodule
